FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked every clock, quiet while rst is high
`define WDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked every clock, reset included
`define WDA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WDA_ASSERT(lbl, prop, msg)
`define WDA_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: rtl/wda_pkg.sv
// ----------------------------------------------------------------------------
// wda_pkg
// Types and constants for the wind drag acceleration pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package wda_pkg;

  localparam int VEL_BITS    = 24;
  localparam int MASS_W      = 24;
  localparam int COEF_W      = 20;
  localparam int ABS_W       = VEL_BITS + 1;        // |wind - craft|
  localparam int SS_W        = 2 * ABS_W;           // sum of squares
  localparam int ROOT_W      = ABS_W;               // floor sqrt
  localparam int MAG_W       = ABS_W + ROOT_W;      // |rel_i| * |rel|
  localparam int K_W         = 3 * COEF_W;          // rho * cd * area
  localparam int PROD_W      = MAG_W + K_W;
  localparam int SCALE_SHIFT = 40;
  localparam int NUM_W       = PROD_W - SCALE_SHIFT;
  localparam int DRAG_DIV    = 200;
  localparam int DEN_W       = MASS_W + 8;          // 200 * mass
  localparam int SPLIT_W     = 30;                  // partial product split
  localparam int MHI_W       = MAG_W - SPLIT_W;
  localparam int KHI_W       = K_W - SPLIT_W;
  localparam int MID_W       = 2 * SPLIT_W + 1;

  localparam logic [MASS_W-1:0] MASS_MIN = MASS_W'(7);

  localparam logic [1:0] REG_ENABLE  = 2'd0;
  localparam logic [1:0] REG_DENSITY = 2'd1;
  localparam logic [1:0] REG_COEFF   = 2'd2;
  localparam logic [1:0] REG_AREA    = 2'd3;

  localparam logic [COEF_W-1:0] DENSITY_RST = COEF_W'(80282);
  localparam logic [COEF_W-1:0] COEFF_RST   = COEF_W'(65536);
  localparam logic [COEF_W-1:0] AREA_RST    = COEF_W'(655);

  typedef struct packed {
    logic signed [VEL_BITS-1:0] wind_x;
    logic signed [VEL_BITS-1:0] wind_y;
    logic signed [VEL_BITS-1:0] wind_z;
    logic signed [VEL_BITS-1:0] craft_vx;
    logic signed [VEL_BITS-1:0] craft_vy;
    logic signed [VEL_BITS-1:0] craft_vz;
    logic        [MASS_W-1:0]   craft_mass;
  } wda_in_t;

  typedef struct packed {
    logic signed [VEL_BITS-1:0] accel_x;
    logic signed [VEL_BITS-1:0] accel_y;
    logic signed [VEL_BITS-1:0] accel_z;
    logic                       accel_saturated;
  } wda_out_t;

  // Side data riding alongside the arithmetic
  typedef struct packed {
    logic                       kill;
    logic [2:0]                 neg;
    logic [2:0][ABS_W-1:0]      absr;
    logic [DEN_W-1:0]           den;
  } wda_side_t;

endpackage
`default_nettype wire

FILE: rtl/wda_sqrt.sv
// ----------------------------------------------------------------------------
// wda_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module wda_sqrt import wda_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [SS_W-1:0]   rad,
  output logic      [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 2;

  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SS_W-1:0]   rad_q  [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [SS_W-1:0]   rad_p;
    logic [REM_W+1:0]  t;
    logic [REM_W+1:0]  trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad;
    end else begin : g_rest
      assign rem_p  = rem_q[j-1];
      assign root_p = root_q[j-1];
      assign rad_p  = rad_q[j-1];
    end

    assign t     = {rem_p, rad_p[SS_W-1 -: 2]};
    assign trial = (REM_W+2)'({root_p, 2'b01});
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j]  <= ge ? REM_W'(t - trial) : REM_W'(t);
        root_q[j] <= {root_p[ROOT_W-2:0], ge};
        rad_q[j]  <= rad_p << 2;
      end
    end
  end

  assign root = root_q[ROOT_W-1];

endmodule
`default_nettype wire

FILE: rtl/wda_div.sv
// ----------------------------------------------------------------------------
// wda_div
// Pipelined restoring divider with overflow detect, one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none
module wda_div import wda_pkg::*; (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [NUM_W-1:0]    num,
  input  wire logic [DEN_W-1:0]    den,
  output logic      [VEL_BITS-1:0] quo,
  output logic                     ovf
);

  localparam int NH_W = NUM_W - VEL_BITS;

  logic [DEN_W-1:0]    rem_q [VEL_BITS+1];
  logic [DEN_W-1:0]    den_q [VEL_BITS+1];
  logic [VEL_BITS-1:0] low_q [VEL_BITS+1];
  logic [VEL_BITS-1:0] quo_q [VEL_BITS+1];
  logic                ovf_q [VEL_BITS+1];

  // Entry stage: the quotient fits VEL_BITS bits only if num >> VEL_BITS < den
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= DEN_W'(num[NUM_W-1:VEL_BITS]);
      ovf_q[0] <= (num[NUM_W-1:VEL_BITS] >= NH_W'(den));
      den_q[0] <= den;
      low_q[0] <= num[VEL_BITS-1:0];
      quo_q[0] <= '0;
    end
  end

  for (genvar k = 1; k <= VEL_BITS; k++) begin : g_stage
    logic [DEN_W:0] t;
    logic           ge;

    assign t  = {rem_q[k-1], low_q[k-1][VEL_BITS-1]};
    assign ge = (t >= {1'b0, den_q[k-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? DEN_W'(t - {1'b0, den_q[k-1]}) : DEN_W'(t);
        den_q[k] <= den_q[k-1];
        low_q[k] <= low_q[k-1] << 1;
        quo_q[k] <= {quo_q[k-1][VEL_BITS-2:0], ge};
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo = quo_q[VEL_BITS];
  assign ovf = ovf_q[VEL_BITS];

endmodule
`default_nettype wire

FILE: rtl/wind_drag_acceleration.sv
// Throughput: one beat per cycle while the output is not stalled; the 25-stage square
// root and the 25-stage divider are fully pipelined, so the stage count sets the latency
// and not the rate.
// A stalled output freezes the whole pipeline; input ready follows output space.
// Reset (rst, synchronous): clears all stage valids and loads the register defaults.
// ----------------------------------------------------------------------------
// wind_drag_acceleration
// Quadratic drag acceleration from wind and vehicle velocity, pipelined.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module wind_drag_acceleration import wda_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire wda_in_t     req_data,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output wda_out_t         rsp_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int P3 = 3;
  localparam int PR = P3 + ROOT_W;
  localparam int PM = PR + 1;
  localparam int PP = PM + 1;
  localparam int PQ = PP + 1;
  localparam int PN = PQ + 1;
  localparam int PD = PN + VEL_BITS + 1;
  localparam int PO = PD + 1;

  localparam logic [VEL_BITS-1:0] POS_LIM = {1'b0, {(VEL_BITS-1){1'b1}}};
  localparam logic [VEL_BITS-1:0] NEG_LIM = {1'b1, {(VEL_BITS-1){1'b0}}};

  // Configuration
  logic              drag_enabled;
  logic [COEF_W-1:0] air_density;
  logic [COEF_W-1:0] drag_coeff;
  logic [COEF_W-1:0] frontal_area;
  logic [2*COEF_W-1:0] coef_k1;
  logic [K_W-1:0]      coef_k;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      drag_enabled <= 1'b1;
      air_density  <= DENSITY_RST;
      drag_coeff   <= COEFF_RST;
      frontal_area <= AREA_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ENABLE:  drag_enabled <= pwdata[0];
        REG_DENSITY: air_density  <= pwdata[COEF_W-1:0];
        REG_COEFF:   drag_coeff   <= pwdata[COEF_W-1:0];
        REG_AREA:    frontal_area <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ENABLE:  prdata = {31'b0, drag_enabled};
      REG_DENSITY: prdata = 32'(air_density);
      REG_COEFF:   prdata = 32'(drag_coeff);
      REG_AREA:    prdata = 32'(frontal_area);
      default:     prdata = '0;
    endcase
  end

  // Coefficient product K = rho * cd * area, registered in coef_k1 and then in coef_k
  always_ff @(posedge clk) begin
    coef_k1 <= air_density * drag_coeff;
    coef_k  <= coef_k1 * (2*COEF_W)'(frontal_area);
  end

  // Pipeline control
  logic          en;
  logic [PO:1]   vld;
  wda_side_t     side_q [1:PD];

  assign en        = !vld[PO] || rsp_ready;
  assign req_ready = en;
  assign rsp_valid = vld[PO];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PO-1:1], req_valid};
    end
  end

  // Stage 1: relative wind, sign and magnitude per axis, early-out checks
  logic signed [VEL_BITS-1:0] wind  [3];
  logic signed [VEL_BITS-1:0] craft [3];
  wda_side_t                  side_in;

  assign wind[0]  = req_data.wind_x;
  assign wind[1]  = req_data.wind_y;
  assign wind[2]  = req_data.wind_z;
  assign craft[0] = req_data.craft_vx;
  assign craft[1] = req_data.craft_vy;
  assign craft[2] = req_data.craft_vz;

  always_comb begin
    logic signed [ABS_W-1:0] rel;
    logic                    any;
    any = 1'b0;
    for (int i = 0; i < 3; i++) begin
      rel = ABS_W'(wind[i]) - ABS_W'(craft[i]);
      side_in.neg[i]  = rel[ABS_W-1];
      side_in.absr[i] = rel[ABS_W-1] ? ABS_W'(-rel) : ABS_W'(rel);
      any = any || (rel != '0);
    end
    side_in.kill = !drag_enabled || (req_data.craft_mass < MASS_MIN) || !any;
    side_in.den  = DEN_W'(req_data.craft_mass) * DEN_W'(DRAG_DIV);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[1] <= side_in;
      for (int k = 2; k <= PD; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Stages 2 and 3: squares, then their sum
  logic [SS_W-1:0] sq_q [3];
  logic [SS_W-1:0] ss_q;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= SS_W'(side_q[1].absr[i]) * SS_W'(side_q[1].absr[i]);
      end
      ss_q <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  logic [ROOT_W-1:0] root;

  wda_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (ss_q),
    .root (root)
  );

  // Product |rel_i| * |rel| * K, cut into four partial products per axis
  logic [MAG_W-1:0]         mag_q  [3];
  logic [2*SPLIT_W-1:0]     pp00_q [3];
  logic [2*SPLIT_W-1:0]     pp01_q [3];
  logic [MHI_W+SPLIT_W-1:0] pp10_q [3];
  logic [MHI_W+KHI_W-1:0]   pp11_q [3];
  logic [MID_W-1:0]         mid_q  [3];
  logic [PROD_W-1:0]        cat_q  [3];
  logic [NUM_W-1:0]         num_q  [3];

  always_ff @(posedge clk) begin
    logic [PROD_W-1:0] prod;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i]  <= MAG_W'(side_q[PR].absr[i]) * MAG_W'(root);
        pp00_q[i] <= (2*SPLIT_W)'(mag_q[i][SPLIT_W-1:0]) *
                     (2*SPLIT_W)'(coef_k[SPLIT_W-1:0]);
        pp01_q[i] <= (2*SPLIT_W)'(mag_q[i][SPLIT_W-1:0]) *
                     (2*SPLIT_W)'(coef_k[K_W-1:SPLIT_W]);
        pp10_q[i] <= (MHI_W+SPLIT_W)'(mag_q[i][MAG_W-1:SPLIT_W]) *
                     (MHI_W+SPLIT_W)'(coef_k[SPLIT_W-1:0]);
        pp11_q[i] <= (MHI_W+KHI_W)'(mag_q[i][MAG_W-1:SPLIT_W]) *
                     (MHI_W+KHI_W)'(coef_k[K_W-1:SPLIT_W]);
        // outer terms do not overlap
        cat_q[i]  <= {pp11_q[i], pp00_q[i]};
        mid_q[i]  <= MID_W'(pp01_q[i]) + MID_W'(pp10_q[i]);
        prod       = cat_q[i] + (PROD_W'(mid_q[i]) << SPLIT_W);
        num_q[i]  <= prod[PROD_W-1:SCALE_SHIFT];
      end
    end
  end

  logic [VEL_BITS-1:0] quo [3];
  logic                ovf [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    wda_div u_div (
      .clk (clk),
      .en  (en),
      .num (num_q[i]),
      .den (side_q[PN].den),
      .quo (quo[i]),
      .ovf (ovf[i])
    );
  end

  // Output: clamp, sign, zero on the early-out cases
  wda_out_t rsp_next;

  always_comb begin
    logic [VEL_BITS-1:0] lim;
    logic [VEL_BITS-1:0] mag;
    logic [VEL_BITS-1:0] res [3];
    logic                sat;
    logic                any_sat;
    any_sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      lim = side_q[PD].neg[i] ? NEG_LIM : POS_LIM;
      sat = ovf[i] || (quo[i] > lim);
      mag = sat ? lim : quo[i];
      res[i] = side_q[PD].neg[i] ? VEL_BITS'(-mag) : mag;
      if (side_q[PD].kill) begin
        res[i] = '0;
        sat    = 1'b0;
      end
      any_sat = any_sat || sat;
    end
    rsp_next.accel_x         = res[0];
    rsp_next.accel_y         = res[1];
    rsp_next.accel_z         = res[2];
    rsp_next.accel_saturated = any_sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp_data <= rsp_next;
    end
  end

  logic kill_out;
  logic at_lim;

  assign kill_out = vld[PD] && en && side_q[PD].kill;
  assign at_lim   = (rsp_data.accel_x == POS_LIM) || (rsp_data.accel_x == NEG_LIM) ||
                    (rsp_data.accel_y == POS_LIM) || (rsp_data.accel_y == NEG_LIM) ||
                    (rsp_data.accel_z == POS_LIM) || (rsp_data.accel_z == NEG_LIM);

  `WDA_ASSERT_RST(a_rst_empty, $past(rst) |-> !rsp_valid, "result valid right after reset")
  `WDA_ASSERT(a_kill_zero, kill_out |=> (rsp_data == '0), "early-out beat not zero")
  `WDA_ASSERT(a_sat_at_lim, (rsp_valid && rsp_data.accel_saturated) |-> at_lim, "flag, no clamp")

endmodule
`default_nettype wire
